// ----- rtl/x86_modrm_source_operand_fetch_assert.svh -----
// Assertion macros used by the checker file.
`ifndef X86_MODRM_SOURCE_OPERAND_FETCH_ASSERT_SVH
`define X86_MODRM_SOURCE_OPERAND_FETCH_ASSERT_SVH

// same-cycle implication
`define XMSOF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XMSOF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/xmsof_pkg.sv -----
package xmsof_pkg;

   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = $clog2(REG_COUNT);

   typedef logic [15:0]          word_type;
   typedef logic [1:0]           size_type;
   typedef logic [19:0]          addr_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   typedef enum logic [2:0] {
      CMD_IMM      = 3'd0,
      CMD_DISP     = 3'd1,
      CMD_RM       = 3'd2,
      CMD_REG      = 3'd3,
      CMD_WRITE    = 3'd4,
      CMD_MEM_DATA = 3'd5,
      CMD_NEW      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_REG    = 2'd1,
      KIND_MEM    = 2'd2
   } kind_type;

   localparam logic [1:0] MOD_NO_DISP = 2'b00;
   localparam logic [1:0] MOD_REG     = 2'b11;
   localparam logic [2:0] RM_DIRECT   = 3'b110;

   // r/m addressing modes
   localparam logic [2:0] RM_BX_SI = 3'd0;
   localparam logic [2:0] RM_BX_DI = 3'd1;
   localparam logic [2:0] RM_BP_SI = 3'd2;
   localparam logic [2:0] RM_BP_DI = 3'd3;
   localparam logic [2:0] RM_SI    = 3'd4;
   localparam logic [2:0] RM_DI    = 3'd5;
   localparam logic [2:0] RM_BX    = 3'd7;

   localparam reg_idx_type IDX_BX = 3'd3;
   localparam reg_idx_type IDX_BP = 3'd5;
   localparam reg_idx_type IDX_SI = 3'd6;
   localparam reg_idx_type IDX_DI = 3'd7;

   localparam size_type SIZE_NONE = 2'd0;
   localparam size_type SIZE_BYTE = 2'd1;
   localparam size_type SIZE_WORD = 2'd2;

   // a size code of three saturates to a word
   function automatic size_type clamp_size(input size_type b);
      return (b > SIZE_WORD) ? SIZE_WORD : b;
   endfunction

   typedef struct packed {
      kind_type kind;
      logic     slot;
      size_type bytes;
      word_type value;      // direct value, or displacement for memory operands
      logic     byte_mode;
      logic     high_byte;
      logic     use_b;
      logic     disp_only;
      logic     add_disp;
      logic     vld_a;
      logic     vld_b;
   } stage_type;

endpackage

// ----- rtl/xmsof_ram.sv -----
module xmsof_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/x86_modrm_source_operand_fetch.sv -----
// Source operand fetch for 8086-style microcode steps.
// Input channel (req_*): one microcode step per item, valid/stall handshake.
// Commands fetch an immediate, a displacement, a ModRM reg or r/m operand,
// write the register file, return data for a pending memory read, or start
// a new instruction. Register writes, new-instruction steps and data with
// no pending read produce no result item.
// Result channel (rsp_*): one item per fetch; a memory r/m operand comes out
// as a read request (mem_request set, operand_valid clear) and its value
// later as a separate item when the data command arrives.
// An accepted step is registered in stage 1 and then in the output register
// that drives rsp_valid. The register file read (two copies of an 8x16
// synchronous RAM, one per read port) is clocked at the accepting edge; the
// base/index/displacement and segment adds then feed the output register.
// Throughput is one item per cycle while the result is not stalled, also
// with a register write directly before a read of the same register.
// Reset (synchronous) empties the pipeline, clears the slot and pending
// state, the data segment, and marks all registers as reading zero.
// A stalled result holds the output register; once the middle stage holds
// an item too, req_stall rises until the result is taken.
module x86_modrm_source_operand_fetch (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_cmd,
   input  logic [7:0]             req_modrm_byte,
   input  logic                   req_byte_mode,
   input  xmsof_pkg::word_type    req_imm_value,
   input  xmsof_pkg::size_type    req_imm_bytes,
   input  xmsof_pkg::word_type    req_disp_value,
   input  xmsof_pkg::size_type    req_disp_bytes,
   input  xmsof_pkg::reg_idx_type req_write_index,
   input  xmsof_pkg::word_type    req_write_value,
   input  xmsof_pkg::word_type    req_mem_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_slot,
   output xmsof_pkg::word_type    rsp_operand_value,
   output xmsof_pkg::size_type    rsp_operand_bytes,
   output logic                   rsp_operand_valid,
   output logic                   rsp_mem_request,
   output xmsof_pkg::addr_type    rsp_read_address,
   input  logic                   csr_write_enable,
   input  xmsof_pkg::word_type    csr_write_data
);

   import xmsof_pkg::*;

   logic        req_acc;
   logic        s1_adv;
   logic        out_load;

   logic        slot_a_ff, slot_a_in;
   logic        pend_slot_ff, pend_slot_in;
   size_type    pend_bytes_ff, pend_bytes_in;
   word_type    dseg_ff;
   logic [REG_COUNT-1:0] reg_vld_ff;

   logic        s1_valid_ff;
   stage_type   s1_ff, s1_in;
   logic        s1_load;

   reg_idx_type addr_a, addr_b;
   word_type    rd_a, rd_b;
   word_type    op_a, op_b;

   logic [1:0]  mod_f;
   logic [2:0]  reg_f, rm_f;

   logic        rsp_valid_ff;
   logic        rsp_slot_ff, rsp_slot_in;
   word_type    rsp_value_ff, rsp_value_in;
   size_type    rsp_bytes_ff, rsp_bytes_in;
   logic        rsp_opv_ff, rsp_opv_in;
   logic        rsp_req_ff, rsp_req_in;
   addr_type    rsp_addr_ff, rsp_addr_in;
   word_type    offset;

   assign s1_adv    = !s1_valid_ff || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !s1_adv;
   assign req_acc   = req_valid && !req_stall;
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   assign mod_f = req_modrm_byte[7:6];
   assign reg_f = req_modrm_byte[5:3];
   assign rm_f  = req_modrm_byte[2:0];

   // ---- decode at accept: control state and register file addresses ----
   always_comb begin
      slot_a_in     = slot_a_ff;
      pend_slot_in  = pend_slot_ff;
      pend_bytes_in = pend_bytes_ff;
      s1_load       = 1'b0;
      s1_in         = '0;
      s1_in.kind    = KIND_DIRECT;
      addr_a        = '0;
      addr_b        = '0;

      case (req_cmd)
         CMD_IMM: begin
            s1_load     = 1'b1;
            s1_in.slot  = slot_a_ff;
            s1_in.value = req_imm_value;
            s1_in.bytes = clamp_size(req_imm_bytes);
            slot_a_in   = 1'b1;
         end
         CMD_DISP: begin
            s1_load     = 1'b1;
            s1_in.slot  = slot_a_ff;
            s1_in.value = req_disp_value;
            s1_in.bytes = clamp_size(req_disp_bytes);
            slot_a_in   = 1'b1;
         end
         CMD_RM: begin
            s1_load         = 1'b1;
            s1_in.slot      = slot_a_ff;
            s1_in.bytes     = req_byte_mode ? SIZE_BYTE : SIZE_WORD;
            s1_in.byte_mode = req_byte_mode;
            slot_a_in       = 1'b1;
            if (mod_f == MOD_REG) begin
               s1_in.kind      = KIND_REG;
               addr_a          = req_byte_mode ? {1'b0, rm_f[1:0]} : rm_f;
               s1_in.high_byte = req_byte_mode && rm_f[2];
            end else begin
               s1_in.kind      = KIND_MEM;
               s1_in.value     = req_disp_value;
               s1_in.disp_only = (mod_f == MOD_NO_DISP) && (rm_f == RM_DIRECT);
               s1_in.add_disp  = (mod_f != MOD_NO_DISP);
               pend_slot_in    = slot_a_ff;
               pend_bytes_in   = req_byte_mode ? SIZE_BYTE : SIZE_WORD;
               case (rm_f)
                  RM_BX_SI: begin addr_a = IDX_BX; addr_b = IDX_SI; s1_in.use_b = 1'b1; end
                  RM_BX_DI: begin addr_a = IDX_BX; addr_b = IDX_DI; s1_in.use_b = 1'b1; end
                  RM_BP_SI: begin addr_a = IDX_BP; addr_b = IDX_SI; s1_in.use_b = 1'b1; end
                  RM_BP_DI: begin addr_a = IDX_BP; addr_b = IDX_DI; s1_in.use_b = 1'b1; end
                  RM_SI: addr_a = IDX_SI;
                  RM_DI: addr_a = IDX_DI;
                  RM_DIRECT: addr_a = IDX_BP;
                  default: addr_a = IDX_BX;
               endcase
            end
         end
         CMD_REG: begin
            s1_load         = 1'b1;
            s1_in.kind      = KIND_REG;
            s1_in.slot      = slot_a_ff;
            s1_in.bytes     = req_byte_mode ? SIZE_BYTE : SIZE_WORD;
            s1_in.byte_mode = req_byte_mode;
            s1_in.high_byte = req_byte_mode && reg_f[2];
            addr_a          = req_byte_mode ? {1'b0, reg_f[1:0]} : reg_f;
            slot_a_in       = 1'b1;
         end
         CMD_MEM_DATA: begin
            if (pend_bytes_ff != SIZE_NONE) begin
               s1_load       = 1'b1;
               s1_in.slot    = pend_slot_ff;
               s1_in.bytes   = pend_bytes_ff;
               s1_in.value   = (pend_bytes_ff == SIZE_BYTE) ?
                               {8'h00, req_mem_data[7:0]} : req_mem_data;
               pend_bytes_in = SIZE_NONE;
            end
         end
         CMD_NEW: begin
            slot_a_in     = 1'b0;
            pend_bytes_in = SIZE_NONE;
         end
         default: begin
         end
      endcase

      // never-written registers read as zero
      s1_in.vld_a = reg_vld_ff[addr_a];
      s1_in.vld_b = reg_vld_ff[addr_b];
   end

   // two copies of the register file, one per read port
   xmsof_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (req_acc && (req_cmd == CMD_WRITE)),
      .wr_addr (req_write_index),
      .wr_data (req_write_value),
      .rd_en   (req_acc),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   xmsof_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (req_acc && (req_cmd == CMD_WRITE)),
      .wr_addr (req_write_index),
      .wr_data (req_write_value),
      .rd_en   (req_acc),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_a_ff     <= 1'b0;
         pend_slot_ff  <= 1'b0;
         pend_bytes_ff <= SIZE_NONE;
         reg_vld_ff    <= '0;
         dseg_ff       <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (req_acc) begin
            slot_a_ff     <= slot_a_in;
            pend_slot_ff  <= pend_slot_in;
            pend_bytes_ff <= pend_bytes_in;
            if (req_cmd == CMD_WRITE) begin
               reg_vld_ff[req_write_index] <= 1'b1;
            end
         end
         if (csr_write_enable) begin
            dseg_ff <= csr_write_data;
         end
         if (s1_adv) begin
            s1_valid_ff <= req_acc && s1_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
   end

   // ---- stage 1: operand select and address add ----
   assign op_a = s1_ff.vld_a ? rd_a : '0;
   assign op_b = (s1_ff.use_b && s1_ff.vld_b) ? rd_b : '0;

   always_comb begin
      rsp_slot_in  = s1_ff.slot;
      rsp_bytes_in = s1_ff.bytes;
      rsp_value_in = s1_ff.value;
      rsp_opv_in   = 1'b1;
      rsp_req_in   = 1'b0;
      rsp_addr_in  = '0;
      offset       = '0;
      case (s1_ff.kind)
         KIND_REG: begin
            if (!s1_ff.byte_mode) begin
               rsp_value_in = op_a;
            end else if (s1_ff.high_byte) begin
               rsp_value_in = {8'h00, op_a[15:8]};
            end else begin
               rsp_value_in = {8'h00, op_a[7:0]};
            end
         end
         KIND_MEM: begin
            // offsets wrap at 16 bits, physical address at 20
            offset = s1_ff.disp_only ? s1_ff.value :
                     op_a + op_b + (s1_ff.add_disp ? s1_ff.value : 16'h0000);
            rsp_value_in = '0;
            rsp_opv_in   = 1'b0;
            rsp_req_in   = 1'b1;
            rsp_addr_in  = {dseg_ff, 4'h0} + {4'h0, offset};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_slot_ff  <= rsp_slot_in;
         rsp_value_ff <= rsp_value_in;
         rsp_bytes_ff <= rsp_bytes_in;
         rsp_opv_ff   <= rsp_opv_in;
         rsp_req_ff   <= rsp_req_in;
         rsp_addr_ff  <= rsp_addr_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_operand_value = rsp_value_ff;
   assign rsp_operand_bytes = rsp_bytes_ff;
   assign rsp_operand_valid = rsp_opv_ff;
   assign rsp_mem_request   = rsp_req_ff;
   assign rsp_read_address  = rsp_addr_ff;

endmodule

// ----- rtl/xmsof_checker.sv -----
`include "x86_modrm_source_operand_fetch_assert.svh"

module xmsof_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_operand_valid,
   input logic                rsp_mem_request,
   input xmsof_pkg::addr_type rsp_read_address
);

   import xmsof_pkg::*;

   `XMSOF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result item dropped while stalled")

   // an item is either a final operand or a read request, never both
   `XMSOF_ASSERT_IMPLY(a_kind_excl, clock, reset, rsp_valid, rsp_operand_valid != rsp_mem_request, "operand_valid and mem_request not exclusive")

   `XMSOF_ASSERT_IMPLY(a_addr_zero, clock, reset, rsp_valid && !rsp_mem_request, rsp_read_address == '0, "read address set without a request")

   `XMSOF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

endmodule

bind x86_modrm_source_operand_fetch xmsof_checker u_xmsof_checker (.*);
